FILE: hdl/flash_erase_program_sequencer_assert.svh
// Assertion macros for the flash sequencer
`ifndef FLASH_ERASE_PROGRAM_SEQUENCER_ASSERT_SVH
`define FLASH_ERASE_PROGRAM_SEQUENCER_ASSERT_SVH
`define FEPS_ASSERT_IMPL(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (c)) else $error("assertion failed");
`define FEPS_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (c)) else $error("assertion failed");
`endif

FILE: hdl/feps_pkg.sv
// ----------------------------------------------------------------------------
// feps_pkg
// Shared codes and command types for the flash sequencer.
// ----------------------------------------------------------------------------
package feps_pkg;
  localparam int WORD_BYTES = 8;
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PREPARE = 3'd1;
  localparam logic [2:0] PH_ERASE_WAIT = 3'd2;
  localparam logic [2:0] PH_PROGRAM_WAIT = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_FAILED = 3'd5;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BUSY = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_IO = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;
  localparam logic [2:0] ST_DEVICE = 3'd6;
  localparam logic [2:0] ST_UNDEF = 3'd7;
  localparam logic [1:0] FN_BEGIN = 2'd0;
  localparam logic [1:0] FN_TICK = 2'd1;
  localparam logic [1:0] FN_CANCEL = 2'd2;
  localparam logic [1:0] BR_OK = 2'd0;
  localparam logic [1:0] BR_BUSY = 2'd1;
  localparam logic [1:0] BR_INVALID = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ERASE = 2'd1;
  localparam logic [1:0] CMD_PROGRAM = 2'd2;
  localparam logic [2:0] CFG_SLOT0 = 3'd0;
  localparam logic [2:0] CFG_SLOT1 = 3'd1;
  localparam logic [2:0] CFG_SLOT_BYTES = 3'd2;
  localparam logic [2:0] CFG_SECTOR = 3'd3;
  localparam logic [2:0] CFG_ALIGN = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic div_start;      // start remainder
    logic div_sel_sector; // 1: pos % sector, 0: off % align
    logic load_begin;     // arm write from begin item
    logic clr_erased;
    logic set_erased;     // erased_limit = base + sector
    logic load_time;
    logic add_chunk;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic pos_ge_erased;
    logic done_all;
    logic timed_out;
    logic begin_bad;      // bounds and length check failed
  } dp_stat_t;
endpackage

FILE: hdl/flash_erase_program_sequencer.sv
// ----------------------------------------------------------------------------
// flash_erase_program_sequencer
// Erase-before-write sequencer for two flash image slots. Each item yields
// one result. Items that need a remainder (begin alignment check, erase
// sector base) wait in a state for the bit-serial remainder unit before the
// finish state registers the result; all other items go from the input
// transfer straight to the finish state. One item is in work at a time; the
// item fields are captured at the input transfer.
// ----------------------------------------------------------------------------
module flash_erase_program_sequencer import feps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_slot,
  input  logic [31:0] in_start_offset,
  input  logic [31:0] in_length,
  input  logic [63:0] in_data_word,
  input  logic [2:0]  in_poll_status,
  input  logic [2:0]  in_issue_status,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_begin_result,
  output logic [2:0]  out_writer_status,
  output logic [1:0]  out_command,
  output logic [31:0] out_command_address,
  output logic [63:0] out_program_data,
  output logic [2:0]  out_phase,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  `include "flash_erase_program_sequencer_assert.svh"

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] erase_addr, prog_addr;
  logic [63:0] prog_data;

  // item fields latched so they hold while the item works
  logic [31:0] off_r, len_r, now_r;
  logic [63:0] dw_r;
  logic [1:0]  slot_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      off_r <= in_start_offset; len_r <= in_length; now_r <= in_time_now;
      dw_r <= in_data_word; slot_r <= in_slot;
    end
  end

  feps_controller u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_slot(in_slot),
    .in_start_offset((in_valid && in_ready) ? in_start_offset : off_r),
    .in_poll_status(in_poll_status), .in_issue_status(in_issue_status),
    .out_valid(out_valid), .out_ready(out_ready), .out_begin_result(out_begin_result),
    .out_writer_status(out_writer_status), .out_command(out_command),
    .out_command_address(out_command_address), .out_program_data(out_program_data),
    .out_phase(out_phase), .cmd(cmd), .stat(stat), .erase_addr(erase_addr),
    .prog_addr(prog_addr), .prog_data(prog_data)
  );

  feps_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .slot(slot_r),
    .start_offset((in_valid && in_ready) ? in_start_offset : off_r),
    .length(len_r), .data_word(dw_r), .time_now(now_r),
    .cmd(cmd), .stat(stat), .erase_addr(erase_addr), .prog_addr(prog_addr),
    .prog_data(prog_data)
  );

  `FEPS_ASSERT_IMPL(a_no_accept_stall, out_valid && !out_ready, !in_ready)
  `FEPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_command_address))
  `FEPS_ASSERT_IMPL(a_phase_range, out_valid, out_phase <= PH_FAILED)
endmodule

FILE: hdl/feps_divider.sv
// ----------------------------------------------------------------------------
// feps_divider
// Bit-serial 32-bit remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module feps_divider import feps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  logic [31:0] rem_r, rem_nxt, num_r, num_nxt, dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt = rem_r; num_nxt = num_r; dvs_nxt = dvs_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, num_r[31]};
    if (start) begin
      rem_nxt = '0; num_nxt = dividend;
      dvs_nxt = (divisor == '0) ? 32'd1 : divisor;
      cnt_nxt = 6'd32; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) rem_nxt = 32'(trial - {1'b0, dvs_r});
      else rem_nxt = trial[31:0];
      num_nxt = {num_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; num_r <= num_nxt; dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign remainder = rem_r;
endmodule

FILE: hdl/feps_datapath.sv
// ----------------------------------------------------------------------------
// feps_datapath
// Configuration, address and progress registers, remainder unit.
// ----------------------------------------------------------------------------
module feps_datapath import feps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  slot,
  input  logic [31:0] start_offset,
  input  logic [31:0] length,
  input  logic [63:0] data_word,
  input  logic [31:0] time_now,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [31:0] erase_addr,
  output logic [31:0] prog_addr,
  output logic [63:0] prog_data
);
  logic [31:0] slot0_r, slot1_r, sbytes_r, sector_r, align_r, tlim_r;
  logic [31:0] base_r, start_r, erased_r, done_r, total_r, t0_r;
  logic [31:0] pos, sec, rem, left, ebase;
  logic [3:0]  chunk;
  logic        ddone;

  assign pos = start_r + done_r;
  assign sec = (sector_r == '0) ? 32'd1 : sector_r;
  assign left = total_r - done_r;
  assign chunk = (left < 32'(WORD_BYTES)) ? left[3:0] : 4'(WORD_BYTES);
  assign ebase = pos - rem;

  feps_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(cmd.div_sel_sector ? pos : start_offset),
    .divisor(cmd.div_sel_sector ? sector_r : align_r),
    .done(ddone), .remainder(rem)
  );

  always_comb begin
    for (int i = 0; i < 8; i++)
      prog_data[8*i +: 8] = (4'(i) < chunk) ? data_word[8*i +: 8] : 8'hff;
  end

  assign erase_addr = base_r + ebase;
  assign prog_addr = base_r + pos;
  assign stat.div_done = ddone;
  assign stat.rem_zero = (rem == '0);
  assign stat.pos_ge_erased = (pos >= erased_r);
  assign stat.done_all = (done_r >= total_r);
  assign stat.timed_out = (32'(time_now - t0_r) >= tlim_r);
  assign stat.begin_bad = (length == '0) || (start_offset >= sbytes_r) ||
                          (length > sbytes_r - start_offset);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot0_r <= '0; slot1_r <= '0; sbytes_r <= 32'd65536; sector_r <= 32'd4096;
      align_r <= 32'd8; tlim_r <= 32'd1000000;
      base_r <= '0; start_r <= '0; erased_r <= '0; done_r <= '0; total_r <= '0;
      t0_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SLOT0:      slot0_r <= cfg_data;
          CFG_SLOT1:      slot1_r <= cfg_data;
          CFG_SLOT_BYTES: sbytes_r <= cfg_data;
          CFG_SECTOR:     sector_r <= cfg_data;
          CFG_ALIGN:      align_r <= cfg_data;
          CFG_TIMEOUT:    tlim_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_begin) begin
        base_r <= slot[0] ? slot1_r : slot0_r;
        start_r <= start_offset; done_r <= '0; total_r <= length;
      end
      if (cmd.clr_erased) erased_r <= '0;
      if (cmd.set_erased) erased_r <= ebase + sec;
      if (cmd.load_time) t0_r <= time_now;
      if (cmd.add_chunk) done_r <= done_r + 32'(chunk);
    end
  end
endmodule

FILE: hdl/feps_controller.sv
// ----------------------------------------------------------------------------
// feps_controller
// Handshake and phase sequencing; drives the datapath.
// ----------------------------------------------------------------------------
module feps_controller import feps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_slot,
  input  logic [31:0] in_start_offset,
  input  logic [2:0]  in_poll_status,
  input  logic [2:0]  in_issue_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_begin_result,
  output logic [2:0]  out_writer_status,
  output logic [1:0]  out_command,
  output logic [31:0] out_command_address,
  output logic [63:0] out_program_data,
  output logic [2:0]  out_phase,
  output dp_cmd_t     cmd,
  input  dp_stat_t    stat,
  input  logic [31:0] erase_addr,
  input  logic [31:0] prog_addr,
  input  logic [63:0] prog_data
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_FIN = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [2:0]  ph_r, ph_nxt, stat_r, stat_nxt;
  logic        req_r, req_nxt, can_r, can_nxt, ov_r, ov_nxt;
  logic [1:0]  br_r, br_nxt, cm_r, cm_nxt, fn_r, fn_nxt;
  logic [31:0] ad_r, ad_nxt;
  logic [63:0] pd_r, pd_nxt;
  logic [2:0]  poll_r, poll_nxt, iss_r, iss_nxt, r;
  logic [1:0]  slot_r, slot_nxt;
  logic        acc;

  assign in_ready = (st_r == S_IDLE) && (!ov_r || out_ready);
  assign acc = in_valid && in_ready;

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; stat_nxt = stat_r; req_nxt = req_r; can_nxt = can_r;
    ov_nxt = ov_r && !out_ready; br_nxt = br_r; cm_nxt = cm_r; ad_nxt = ad_r;
    pd_nxt = pd_r; fn_nxt = fn_r; poll_nxt = poll_r; iss_nxt = iss_r;
    slot_nxt = slot_r; cmd = '0; r = poll_r;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          fn_nxt = in_func; poll_nxt = in_poll_status; iss_nxt = in_issue_status;
          slot_nxt = in_slot;
          br_nxt = BR_OK; cm_nxt = CMD_NONE; ad_nxt = '0; pd_nxt = '0;
          if (in_func == FN_BEGIN) begin
            if (stat_r == ST_BUSY) begin
              br_nxt = BR_BUSY; st_nxt = S_FIN;
            end else begin
              cmd.div_start = 1'b1; st_nxt = S_DIV;
            end
          end else if (in_func == FN_TICK && ph_r == PH_PREPARE && !can_r &&
                       !stat.done_all && stat.pos_ge_erased) begin
            cmd.div_start = 1'b1; cmd.div_sel_sector = 1'b1; st_nxt = S_DIV;
          end else begin
            st_nxt = S_FIN;
          end
        end
      end
      S_DIV: begin
        cmd.div_sel_sector = (fn_r == FN_TICK);
        if (stat.div_done) st_nxt = S_FIN;
      end
      S_FIN: begin
        st_nxt = S_IDLE; ov_nxt = 1'b1;
        case (fn_r)
          FN_BEGIN: begin
            if (br_r == BR_BUSY) br_nxt = BR_BUSY;
            else if (slot_r[1] || stat.begin_bad || !stat.rem_zero) br_nxt = BR_INVALID;
            else if (poll_r == ST_BUSY) br_nxt = BR_BUSY;
            else begin
              cmd.load_begin = 1'b1;
              if (in_start_offset == '0) cmd.clr_erased = 1'b1;
              req_nxt = 1'b1; can_nxt = 1'b0; stat_nxt = ST_BUSY;
            end
          end
          FN_CANCEL: can_nxt = 1'b1;
          FN_TICK: begin
            case (ph_r)
              PH_PREPARE: begin
                if (can_r) begin
                  stat_nxt = ST_REJECTED; ph_nxt = PH_DONE;
                end else if (stat.done_all) begin
                  stat_nxt = ST_OK; ph_nxt = PH_DONE;
                end else begin
                  cmd.load_time = 1'b1;
                  if (stat.pos_ge_erased) begin
                    cm_nxt = CMD_ERASE; ad_nxt = erase_addr;
                    cmd.set_erased = 1'b1; ph_nxt = PH_ERASE_WAIT;
                  end else begin
                    cm_nxt = CMD_PROGRAM; ad_nxt = prog_addr; pd_nxt = prog_data;
                    ph_nxt = PH_PROGRAM_WAIT;
                  end
                  if (iss_r != ST_OK) begin
                    ph_nxt = PH_FAILED;
                    if (iss_r == ST_BUSY) stat_nxt = ST_IO;
                    else if (iss_r == ST_UNDEF) stat_nxt = ST_DEVICE;
                    else stat_nxt = iss_r;
                  end
                end
              end
              PH_ERASE_WAIT, PH_PROGRAM_WAIT: begin
                if (poll_r == ST_BUSY && stat.timed_out) r = ST_TIMEOUT;
                if (r != ST_BUSY) begin
                  if (r != ST_OK) begin
                    stat_nxt = (r == ST_UNDEF) ? ST_DEVICE : r; ph_nxt = PH_FAILED;
                  end else if (can_r) begin
                    stat_nxt = ST_REJECTED; ph_nxt = PH_DONE;
                  end else begin
                    if (ph_r == PH_PROGRAM_WAIT && !stat.done_all) cmd.add_chunk = 1'b1;
                    ph_nxt = PH_PREPARE;
                  end
                end
              end
              default: begin
                if (req_r) begin
                  req_nxt = 1'b0; ph_nxt = PH_PREPARE;
                end
              end
            endcase
          end
          default: ;
        endcase
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_IDLE; stat_r <= ST_OK; req_r <= 1'b0;
      can_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; stat_r <= stat_nxt; req_r <= req_nxt;
      can_r <= can_nxt; ov_r <= ov_nxt;
    end
    br_r <= br_nxt; cm_r <= cm_nxt; ad_r <= ad_nxt; pd_r <= pd_nxt; fn_r <= fn_nxt;
    poll_r <= poll_nxt; iss_r <= iss_nxt; slot_r <= slot_nxt;
  end

  assign out_valid = ov_r;
  assign out_begin_result = br_r;
  assign out_writer_status = stat_r;
  assign out_command = cm_r;
  assign out_command_address = ad_r;
  assign out_program_data = pd_r;
  assign out_phase = ph_r;
endmodule
